// File: hw/rtl/k80_pkg.sv
// Shared constants, types and the fixed exponential table of the K80 core.
// No dependencies.
package k80_pkg;

    localparam int EXP_TABLE_BITS   = 8;
    localparam int RESULT_FRAC_BITS = 28;
    localparam int EXP_TABLE_SIZE   = 1 << EXP_TABLE_BITS;
    localparam int FRAC_W           = 32 - EXP_TABLE_BITS;

    localparam logic [31:0] LOG2E_Q30   = 32'h5C55_1D95;
    localparam logic [31:0] LN2_Q32     = 32'hB172_17F8;
    localparam logic [31:0] KAPPA_RESET = 32'd16777216;
    localparam logic [31:0] RECIP6      = 32'hAAAA_AAAB;

    localparam int IN_W  = 40;
    localparam int OUT_W = 96;

    localparam int SH_P  = 34 - RESULT_FRAC_BITS;
    localparam int SH_D1 = 62 - RESULT_FRAC_BITS;
    localparam int SH_D2 = 60 - RESULT_FRAC_BITS;

    typedef enum logic [1:0] {
        CLS_SAME,
        CLS_TS,
        CLS_TV
    } pair_cls_t;

    typedef logic [31:0] exp_table_t [EXP_TABLE_SIZE];

    // entry i = 2^(-i/size), Q1.31, series of exp(-t) up to the t^14 term in Q32
    function automatic exp_table_t build_exp_table();
        exp_table_t tab;
        logic [63:0] t;
        logic [63:0] term;
        logic [63:0] sum;
        for (int i = 0; i < EXP_TABLE_SIZE; i++) begin
            t    = ((64'(i) << (32 - EXP_TABLE_BITS)) * 64'(LN2_Q32)) >> 32;
            term = 64'd1 << 32;
            sum  = 64'd1 << 32;
            for (int n = 1; n <= 14; n++) begin
                term = ((term * t) >> 32) / 64'(n);
                if ((n % 2) == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            tab[i] = 32'((sum + 64'd1) >> 1);
        end
        return tab;
    endfunction

    localparam exp_table_t EXP_TABLE = build_exp_table();

    // round half away from zero by sh bits, saturate to signed 32 bits
    function automatic logic [31:0] to_field(logic signed [65:0] v, int sh);
        logic [65:0] mag;
        logic [65:0] q;
        logic [31:0] bits;
        mag = v[65] ? 66'(-v) : 66'(v);
        q   = (mag + (66'd1 << (sh - 1))) >> sh;
        if (v[65]) begin
            if (q > 66'h0_8000_0000) q = 66'h0_8000_0000;
            bits = 32'(66'd0 - q);
        end else begin
            if (q > 66'h0_7FFF_FFFF) q = 66'h0_7FFF_FFFF;
            bits = q[31:0];
        end
        return bits;
    endfunction

endpackage

// File: hw/rtl/k80_transition_probability_core.sv
// K80 substitution probability and derivatives, twelve-stage pipeline.
// Depends on k80_pkg.
// Throughput: one request per cycle while the output is not stalled and no kappa pass runs.
// Each pipeline stage advances on its own, so bubbles collapse under output stalls.
// A kappa write runs a bit-serial divider, then the ST_KR and ST_SQ states derive the
// rates; inputs and config are held off meanwhile. Reset (aresetn low, synchronous)
// starts the same pass for the default kappa of 1.0.
module k80_transition_probability_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [k80_pkg::IN_W-1:0]  s_tdata,  // branch_length, from_base, to_base
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [k80_pkg::OUT_W-1:0] m_tdata,  // probability, first_derivative, second_derivative
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [31:0]               cfg_data
);
    import k80_pkg::*;

    localparam int NS        = 12;
    localparam int DIV_STEPS = 55;

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_KR, ST_SQ} seq_t;

    seq_t        state_reg;
    logic [5:0]  cnt_reg;
    logic [33:0] rem_reg;
    logic [54:0] quo_reg;
    logic [32:0] den_reg;
    logic [31:0] r_reg;
    logic [31:0] k_reg;
    logic [29:0] kr_reg;
    logic [30:0] r2_reg;
    logic [30:0] kr2_reg;

    logic [33:0] trial;
    logic [32:0] cfg_den;

    assign trial     = {rem_reg[32:0], quo_reg[54]} - {1'b0, den_reg};
    assign cfg_den   = {1'b0, cfg_data} + 33'h0_0200_0000;
    assign cfg_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_DIV;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            den_reg   <= {1'b0, KAPPA_RESET} + 33'h0_0200_0000;
            quo_reg   <= (55'd1 << 54)
                         + 55'(({1'b0, KAPPA_RESET} + 33'h0_0200_0000) >> 1);
            k_reg     <= 32'(({1'b0, KAPPA_RESET} + 33'h0_0100_0000) >> 1);
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (cfg_valid) begin
                        state_reg <= ST_DIV;
                        cnt_reg   <= '0;
                        rem_reg   <= '0;
                        den_reg   <= cfg_den;
                        quo_reg   <= (55'd1 << 54) + 55'(cfg_den >> 1);
                        k_reg     <= 32'(({1'b0, cfg_data} + 33'h0_0100_0000) >> 1);
                    end
                end
                ST_DIV: begin
                    if (!trial[33]) begin
                        rem_reg <= trial;
                        quo_reg <= {quo_reg[53:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[32:0], quo_reg[54]};
                        quo_reg <= {quo_reg[53:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(DIV_STEPS - 1)) state_reg <= ST_KR;
                end
                ST_KR: begin
                    r_reg     <= quo_reg[31:0];
                    kr_reg    <= 30'((64'(quo_reg[31:0]) * 64'(k_reg)) >> 24);
                    state_reg <= ST_SQ;
                end
                ST_SQ: begin
                    r2_reg    <= 31'((64'(r_reg) * 64'(r_reg)) >> 28);
                    kr2_reg   <= 31'((64'(kr_reg) * 64'(kr_reg)) >> 28);
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ---------------- item pipeline ----------------
    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !v_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0] && (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= s_tvalid && s_tready;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    pair_cls_t cls_reg [NS-2];
    pair_cls_t in_cls;
    logic [1:0] fb, tb;

    assign fb = s_tdata[33:32];
    assign tb = s_tdata[35:34];
    always_comb begin
        if (fb == tb)             in_cls = CLS_SAME;
        else if ((fb ^ tb) == 2'd2) in_cls = CLS_TS;
        else                      in_cls = CLS_TV;
    end

    logic [35:0]                 x_reg   [2];
    logic                        z1_reg  [2];
    logic [5:0]                  n1_reg  [2];
    logic [EXP_TABLE_BITS-1:0]   idx1_reg[2];
    logic [FRAC_W-1:0]           fr_reg  [2];
    logic                        z2_reg  [2];
    logic [5:0]                  n2_reg  [2];
    logic [EXP_TABLE_BITS-1:0]   idx2_reg[2];
    logic [FRAC_W-1:0]           t2s_t_reg[2];
    logic                        z3_reg  [2];
    logic [5:0]                  n3_reg  [2];
    logic [31:0]                 tab3_reg[2];
    logic [FRAC_W-1:0]           t3s_t_reg[2];
    logic [FRAC_W-1:0]           t3s_t2_reg[2];
    logic                        z4_reg  [2];
    logic [5:0]                  n4_reg  [2];
    logic [31:0]                 tab4_reg[2];
    logic [FRAC_W-1:0]           t4s_t_reg[2];
    logic [FRAC_W-1:0]           t4s_t2_reg[2];
    logic [FRAC_W-1:0]           t4s_t3_reg[2];
    logic                        z5_reg  [2];
    logic [5:0]                  n5_reg  [2];
    logic [31:0]                 tab5_reg[2];
    logic [FRAC_W-1:0]           t5s_t_reg[2];
    logic [FRAC_W-1:0]           t5s_t2_reg[2];
    logic [FRAC_W-1:0]           q6_reg  [2];
    logic                        z6_reg  [2];
    logic [5:0]                  n6_reg  [2];
    logic [31:0]                 tab6_reg[2];
    logic [32:0]                 p_reg   [2];
    logic                        z7_reg  [2];
    logic [5:0]                  n7_reg  [2];
    logic [32:0]                 m_reg   [2];
    logic [32:0]                 e_reg   [2];

    logic [63:0] y [2];
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            y[l] = 64'(x_reg[l][32:0]) * 64'(LOG2E_Q30);
        end
    end

    logic [63:0] re1_reg, kre2_reg, r2e1_reg, kr2e2_reg;
    logic [32:0] e1c_reg, e2c_reg;
    logic signed [65:0] sp_reg, sd1_reg, sd2_reg;
    logic [31:0] prob_reg, d1_reg, d2_reg;

    logic signed [65:0] one_s, e1s, e2s, re1s, kre2s, r2e1s, kr2e2s;
    assign one_s  = 66'sd1 <<< 32;
    assign e1s    = $signed({33'd0, e1c_reg});
    assign e2s    = $signed({33'd0, e2c_reg});
    assign re1s   = $signed({2'd0, re1_reg});
    assign kre2s  = $signed({2'd0, kre2_reg});
    assign r2e1s  = $signed({2'd0, r2e1_reg});
    assign kr2e2s = $signed({2'd0, kr2e2_reg});

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            cls_reg[0] <= in_cls;
            x_reg[0]   <= 36'((64'(r_reg) * 64'(s_tdata[31:0])) >> 26);
            x_reg[1]   <= 36'((64'(kr_reg) * 64'(s_tdata[31:0])) >> 26);
        end
        for (int k = 1; k < NS - 2; k++) begin
            if (en[k]) cls_reg[k] <= cls_reg[k-1];
        end
        for (int l = 0; l < 2; l++) begin
            if (en[1]) begin
                z1_reg[l]   <= |x_reg[l][35:33];
                n1_reg[l]   <= y[l][63:58];
                idx1_reg[l] <= y[l][57 -: EXP_TABLE_BITS];
                fr_reg[l]   <= y[l][57-EXP_TABLE_BITS:26];
            end
            if (en[2]) begin
                z2_reg[l]    <= z1_reg[l];
                n2_reg[l]    <= n1_reg[l];
                idx2_reg[l]  <= idx1_reg[l];
                t2s_t_reg[l] <= FRAC_W'((64'(fr_reg[l]) * 64'(LN2_Q32)) >> 32);
            end
            if (en[3]) begin
                z3_reg[l]     <= z2_reg[l];
                n3_reg[l]     <= n2_reg[l];
                tab3_reg[l]   <= EXP_TABLE[idx2_reg[l]];
                t3s_t_reg[l]  <= t2s_t_reg[l];
                t3s_t2_reg[l] <= FRAC_W'((64'(t2s_t_reg[l]) * 64'(t2s_t_reg[l])) >> 32);
            end
            if (en[4]) begin
                z4_reg[l]     <= z3_reg[l];
                n4_reg[l]     <= n3_reg[l];
                tab4_reg[l]   <= tab3_reg[l];
                t4s_t_reg[l]  <= t3s_t_reg[l];
                t4s_t2_reg[l] <= t3s_t2_reg[l];
                t4s_t3_reg[l] <= FRAC_W'((64'(t3s_t2_reg[l]) * 64'(t3s_t_reg[l])) >> 32);
            end
            if (en[5]) begin
                z5_reg[l]     <= z4_reg[l];
                n5_reg[l]     <= n4_reg[l];
                tab5_reg[l]   <= tab4_reg[l];
                t5s_t_reg[l]  <= t4s_t_reg[l];
                t5s_t2_reg[l] <= t4s_t2_reg[l];
                q6_reg[l]     <= FRAC_W'((64'(t4s_t3_reg[l]) * 64'(RECIP6)) >> 34);
            end
            if (en[6]) begin
                z6_reg[l]   <= z5_reg[l];
                n6_reg[l]   <= n5_reg[l];
                tab6_reg[l] <= tab5_reg[l];
                p_reg[l]    <= (33'd1 << 32) - 33'(t5s_t_reg[l])
                               + 33'(t5s_t2_reg[l] >> 1) - 33'(q6_reg[l]);
            end
            if (en[7]) begin
                z7_reg[l] <= z6_reg[l];
                n7_reg[l] <= n6_reg[l];
                m_reg[l]  <= 33'((64'(tab6_reg[l]) * 64'(p_reg[l])) >> 31);
            end
            if (en[8]) begin
                e_reg[l] <= z7_reg[l] ? 33'd0 : (m_reg[l] >> n7_reg[l]);
            end
        end
        if (en[9]) begin
            e1c_reg   <= e_reg[0];
            e2c_reg   <= e_reg[1];
            re1_reg   <= 64'(r_reg) * 64'(e_reg[0]);
            kre2_reg  <= (64'(kr_reg) * 64'(e_reg[1])) << 1;
            r2e1_reg  <= (64'(r2_reg) * 64'(e_reg[0])) >> 2;
            kr2e2_reg <= (64'(kr2_reg) * 64'(e_reg[1])) >> 1;
        end
        if (en[10]) begin
            unique case (cls_reg[9])
                CLS_SAME: begin
                    sp_reg  <= one_s + e1s + (e2s <<< 1);
                    sd1_reg <= -re1s - kre2s;
                    sd2_reg <= r2e1s + kr2e2s;
                end
                CLS_TS: begin
                    sp_reg  <= one_s + e1s - (e2s <<< 1);
                    sd1_reg <= -re1s + kre2s;
                    sd2_reg <= r2e1s - kr2e2s;
                end
                default: begin
                    sp_reg  <= one_s - e1s;
                    sd1_reg <= re1s;
                    sd2_reg <= -r2e1s;
                end
            endcase
        end
        if (en[11]) begin
            prob_reg <= to_field(sp_reg, SH_P);
            d1_reg   <= to_field(sd1_reg, SH_D1);
            d2_reg   <= to_field(sd2_reg, SH_D2);
        end
    end

    assign m_tvalid = v_reg[NS-1];
    assign m_tdata  = {d2_reg, d1_reg, prob_reg};

    a_no_input_during_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> cfg_ready)
        else $error("input accepted while rates are being derived");

    a_stalled_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[NS-1] && !m_tready) |=> (v_reg[NS-1] && $stable(m_tdata)))
        else $error("stalled result changed");

    a_div_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg < 6'(DIV_STEPS)))
        else $error("divider ran past its step count");

    a_stage_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[5] && !en[5]) |=> v_reg[5])
        else $error("stalled pipeline stage lost its request");

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for k80_transition_probability_core.
// Depends on k80_pkg and the core RTL. It predicts every result with its own
// fixed-point K80 model and compares the probability and both derivatives.
module tb;
    import k80_pkg::*;

    typedef struct packed {
        logic [31:0] d2;
        logic [31:0] d1;
        logic [31:0] p;
    } k80_result_t;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [IN_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic [31:0] cfg_data;

    k80_transition_probability_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    localparam int IDLE_LIMIT = 20000;
    localparam logic [63:0] ONE_Q32 = 64'd1 << 32;

    k80_result_t pending_results[$];
    logic [31:0] pow2_table [EXP_TABLE_SIZE];
    logic [31:0] rate_q28;
    logic [31:0] k_q24;
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          burst_left;
    bit          rx_stalls;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic void fill_pow2_table();
        logic [63:0] t;
        logic [63:0] term;
        logic [63:0] sum;
        for (int i = 0; i < EXP_TABLE_SIZE; i++) begin
            t    = ((64'(i) << (32 - EXP_TABLE_BITS)) * 64'(LN2_Q32)) >> 32;
            term = ONE_Q32;
            sum  = ONE_Q32;
            for (int n = 1; n <= 14; n++) begin
                term = ((term * t) >> 32) / 64'(n);
                if (n % 2 == 1) sum = sum - term;
                else sum = sum + term;
            end
            pow2_table[i] = 32'((sum + 64'd1) >> 1);
        end
    endfunction

    function automatic void set_kappa(logic [31:0] kappa);
        logic [63:0] den;
        den      = 64'(kappa) + (64'd1 << 25);
        rate_q28 = 32'(((64'd1 << 54) + (den >> 1)) / den);
        k_q24    = 32'((64'(kappa) + (64'd1 << 24)) >> 1);
    endfunction

    // exp(-x), x in Q28, result Q32
    function automatic logic [63:0] decay_q32(logic [63:0] x);
        logic [63:0] y, f, idx, rest, t, t2, t3, poly;
        int unsigned n;
        if (x >= (64'd32 << 28)) return 64'd0;
        y    = x * 64'(LOG2E_Q30);
        n    = int'(y >> 58);
        f    = y & ((64'd1 << 58) - 1);
        idx  = f >> (58 - EXP_TABLE_BITS);
        rest = f & ((64'd1 << (58 - EXP_TABLE_BITS)) - 1);
        t    = ((rest >> 26) * 64'(LN2_Q32)) >> 32;
        t2   = (t * t) >> 32;
        t3   = (t2 * t) >> 32;
        poly = ONE_Q32 - t + (t2 >> 1) - t3 / 64'd6;
        return ((64'(pow2_table[idx[EXP_TABLE_BITS-1:0]]) * poly) >> 31) >> n;
    endfunction

    function automatic logic [31:0] round_sat(logic signed [65:0] v, int sh);
        logic [65:0] mag;
        logic [65:0] q;
        mag = v < 0 ? 66'(-v) : 66'(v);
        q   = (mag + (66'd1 << (sh - 1))) >> sh;
        if (v < 0) begin
            if (q > 66'h0_8000_0000) q = 66'h0_8000_0000;
            return 32'(66'd0 - q);
        end
        if (q > 66'h0_7FFF_FFFF) q = 66'h0_7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic k80_result_t k80_predict(logic [31:0] d, logic [1:0] a, logic [1:0] b);
        logic [63:0] r, kr, e1, e2, r2, kr2;
        logic signed [65:0] re1, kre2, r2e1, kr2e2, p, d1, d2;
        pair_cls_t cls;
        k80_result_t res;
        r     = 64'(rate_q28);
        kr    = (r * 64'(k_q24)) >> 24;
        e1    = decay_q32((r * 64'(d)) >> 26);
        e2    = decay_q32((kr * 64'(d)) >> 26);
        r2    = (r * r) >> 28;
        kr2   = (kr * kr) >> 28;
        re1   = 66'(r * e1);
        kre2  = 66'(64'd2 * kr * e2);
        r2e1  = 66'((r2 * e1) >> 2);
        kr2e2 = 66'((kr2 * e2) >> 1);
        cls = (a == b) ? CLS_SAME : ((a ^ b) == 2'd2) ? CLS_TS : CLS_TV;
        case (cls)
            CLS_SAME: begin
                p  = 66'(ONE_Q32 + e1) + 66'(64'd2 * e2);
                d1 = -re1 - kre2;
                d2 = r2e1 + kr2e2;
            end
            CLS_TS: begin
                p  = 66'(ONE_Q32 + e1) - 66'(64'd2 * e2);
                d1 = -re1 + kre2;
                d2 = r2e1 - kr2e2;
            end
            default: begin
                p  = 66'(ONE_Q32) - 66'(e1);
                d1 = re1;
                d2 = -r2e1;
            end
        endcase
        res.p  = round_sat(p, SH_P);
        res.d1 = round_sat(d1, SH_D1);
        res.d2 = round_sat(d2, SH_D2);
        return res;
    endfunction

    // one request; sender idles in bursts
    task automatic send_pair(logic [31:0] d, logic [1:0] a, logic [1:0] b);
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid = 1'b1;
        s_tdata  = {4'd0, b, a, d};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(k80_predict(d, a, b));
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic write_kappa(logic [31:0] kappa);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = kappa;
        do @(posedge aclk); while (!cfg_ready);
        set_kappa(kappa);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] rand_length();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom >> $urandom_range(4, 31);
            default: return $urandom_range(0, 32'h0800_0000);
        endcase
    endfunction

    task automatic test_reset_kappa();
        send_pair(32'd0, 2'd0, 2'd0);
        send_pair(32'h0400_0000, 2'd1, 2'd3);
        send_pair(32'h0400_0000, 2'd2, 2'd1);
    endtask

    task automatic test_all_pairs();
        for (int i = 0; i < 16; i++) send_pair(32'h0100_0000, 2'(i), 2'(i >> 2));
    endtask

    task automatic test_length_extremes();
        send_pair(32'hFFFF_FFFF, 2'd0, 2'd2);
        send_pair(32'hFFFF_FFFF, 2'd3, 2'd3);
        send_pair(32'd1, 2'd3, 2'd0);
        send_pair(32'h5000_0000, 2'd2, 2'd2);
    endtask

    task automatic test_kappa_extremes();
        logic [31:0] kappas [4] = '{32'd1, 32'hFFFF_FFFF, 32'd0, KAPPA_RESET};
        foreach (kappas[i]) begin
            write_kappa(kappas[i]);
            send_pair(32'd0, 2'd1, 2'd1);
            send_pair(32'h0080_0000, 2'd1, 2'd3);
            send_pair(32'hFFFF_FFFF, 2'd0, 2'd1);
            send_pair(32'h0000_4000, 2'd2, 2'd0);
        end
    endtask

    task automatic test_random();
        logic [31:0] kappa;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: kappa = $urandom;
                1: kappa = $urandom_range(32'h0080_0000, 32'h0A00_0000);
                2: kappa = $urandom >> $urandom_range(0, 31);
                default: kappa = $urandom_range(32'h0100_0000, 32'h0400_0000);
            endcase
            write_kappa(kappa);
            repeat (180) send_pair(rand_length(), 2'($urandom), 2'($urandom));
        end
    endtask

    // receiver stall pattern
    initial begin
        m_tready = 1'b1;
        rx_stalls = 1'b0;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 63) == 0) rx_stalls = ~rx_stalls;
            m_tready = rx_stalls ? ($urandom_range(0, 2) != 0) : 1'b1;
        end
    end

    always @(posedge aclk) begin
        k80_result_t want;
        k80_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected p %h d1 %h d2 %h, got p %h d1 %h d2 %h",
                                 want.p, want.d1, want.d2, got.p, got.d1, got.d2);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("k80_transition_probability_core regression: fail");
            $finish;
        end
    end

    initial begin
        int waited;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        burst_left  = 0;
        fill_pow2_table();
        set_kappa(KAPPA_RESET);
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_kappa();
        test_all_pairs();
        test_length_extremes();
        test_kappa_extremes();
        test_random();

        s_tvalid = 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < IDLE_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (30) @(negedge aclk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("k80_transition_probability_core regression: pass");
        else
            $display("k80_transition_probability_core regression: fail");
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/k80_pkg.sv
hw/rtl/k80_transition_probability_core.sv
tb/sv/tb.sv
